[sv/triangle_face_normal_assert.svh]
// Assertion macros for the triangle face normal block.
// Included by triangle_face_normal.sv, which carries the concurrent checks; no other dependencies.
`ifndef TRIANGLE_FACE_NORMAL_ASSERT_SVH
`define TRIANGLE_FACE_NORMAL_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define TFN_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TFN_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TFN_ASSERT(lbl, clk, rst_n, prop, msg)
`define TFN_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

[sv/tfn_pkg.sv]
// Widths and constants for the triangle face normal pipeline.
// Used by tfn_lane and triangle_face_normal; no dependencies.
`default_nettype none
package tfn_pkg;
    localparam int CW  = 16;            // coordinate width
    localparam int NF  = 15;            // fraction bits of the normal, iterations per lane
    localparam int FW  = 16;            // output field width
    localparam int EW  = CW + 1;        // edge width
    localparam int PW  = 2 * EW;        // product width
    localparam int MW  = PW;            // cross product magnitude width
    localparam int LW  = (MW + 1) / 2;  // low half for squaring
    localparam int HW  = MW - LW;       // high half for squaring
    localparam int SQW = 2 * MW;        // square width
    localparam int L2W = SQW + 2;       // squared length width
    localparam int IW  = L2W + 2 * NF + 4; // root search datapath width
    localparam int NFRONT = 6;          // front stages ahead of the lanes
    localparam int NST = NFRONT + NF + 1;  // total register stages
endpackage
`default_nettype wire

[sv/tfn_lane.sv]
// One normal component: bit-per-stage search for round(K*|n_i|/|n|).
// Depends on tfn_pkg.
`default_nettype none
module tfn_lane
    import tfn_pkg::*;
(
    input  logic                  clk,
    input  logic [NF-1:0]         en,
    input  logic [L2W-1:0]        len2,
    input  logic signed [IW-1:0]  rhs,
    input  logic                  neg,
    output logic [NF-1:0]         mag,
    output logic                  neg_out
);
    // s = (2m-1)^2 * len2, a = (2m-1) * len2; rhs = 4K^2 * n_i^2
    logic signed [IW-1:0] s_reg [NF];
    logic signed [IW-1:0] a_reg [NF];
    logic signed [IW-1:0] r_reg [NF];
    logic [L2W-1:0]       l_reg [NF];
    logic [NF-1:0]        m_reg [NF];
    logic [NF-1:0]        n_reg;

    for (genvar k = 0; k < NF; k++) begin : g_it
        localparam int B = NF - 1 - k;
        logic signed [IW-1:0] s_in;
        logic signed [IW-1:0] a_in;
        logic signed [IW-1:0] r_in;
        logic [L2W-1:0]       l_in;
        logic [NF-1:0]        m_in;
        logic                 n_in;
        logic signed [IW-1:0] len_w;
        logic signed [IW-1:0] s_try;
        logic signed [IW-1:0] a_try;
        logic signed [IW-1:0] s_next;
        logic signed [IW-1:0] a_next;
        logic [NF-1:0]        m_next;

        if (k == 0) begin : g_first
            assign s_in = $signed(IW'(len2));
            assign a_in = -$signed(IW'(len2));
            assign r_in = rhs;
            assign l_in = len2;
            assign m_in = '0;
            assign n_in = neg;
        end
        else begin : g_rest
            assign s_in = s_reg[k-1];
            assign a_in = a_reg[k-1];
            assign r_in = r_reg[k-1];
            assign l_in = l_reg[k-1];
            assign m_in = m_reg[k-1];
            assign n_in = n_reg[k-1];
        end

        assign len_w = $signed(IW'(l_in));
        // (2m-1+2^(B+1))^2 = (2m-1)^2 + 2^(B+2)(2m-1) + 2^(2B+2)
        assign s_try = s_in + (a_in <<< (B + 2)) + (len_w <<< (2 * B + 2));
        assign a_try = a_in + (len_w <<< (B + 1));

        always_comb
        begin
            if (s_try <= r_in)
            begin
                s_next = s_try;
                a_next = a_try;
                m_next = m_in | (NF'(1) << B);
            end
            else
            begin
                s_next = s_in;
                a_next = a_in;
                m_next = m_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[k])
            begin
                s_reg[k] <= s_next;
                a_reg[k] <= a_next;
                m_reg[k] <= m_next;
                r_reg[k] <= r_in;
                l_reg[k] <= l_in;
                n_reg[k] <= n_in;
            end
        end
    end

    assign mag     = m_reg[NF-1];
    assign neg_out = n_reg[NF-1];
endmodule
`default_nettype wire

[sv/triangle_face_normal.sv]
// Triangle unit normal: edges, cross product, squared length, then a per-component
// exact rounded root search. Depends on tfn_pkg, tfn_lane and the assert header.
//
//  channel | handshake                 | payload
//  --------+---------------------------+--------------------------------------
//  in      | in_valid / in_stall       | ax ay az bx by bz cx cy cz
//  out     | out_valid / out_stall     | normal_x normal_y normal_z degenerate
//
// One request per clock while the output does not stall; a request passes through the
// six front stages (edges, products, magnitudes, partial squares, squares,
// length), one result bit per stage in each of the three root lanes, and the output register.
// Bubbles collapse: a stage loads whenever it is empty or the next one moves.
// rst_n clears only the stage valid bits.
`default_nettype none
`include "triangle_face_normal_assert.svh"
module triangle_face_normal
    import tfn_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic signed [CW-1:0] ax,
    input  logic signed [CW-1:0] ay,
    input  logic signed [CW-1:0] az,
    input  logic signed [CW-1:0] bx,
    input  logic signed [CW-1:0] by,
    input  logic signed [CW-1:0] bz,
    input  logic signed [CW-1:0] cx,
    input  logic signed [CW-1:0] cy,
    input  logic signed [CW-1:0] cz,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic signed [FW-1:0] normal_x,
    output logic signed [FW-1:0] normal_y,
    output logic signed [FW-1:0] normal_z,
    output logic                 degenerate
);
    logic [NST-1:0] v_reg;
    logic [NST-1:0] en;

    always_comb
    begin
        en[NST-1] = !v_reg[NST-1] || !out_stall;
        for (int k = NST - 2; k >= 0; k--)
            en[k] = !v_reg[k] || en[k+1];
    end

    assign in_stall  = !en[0];
    assign out_valid = v_reg[NST-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
        begin
            if (en[0])
                v_reg[0] <= in_valid;
            for (int k = 1; k < NST; k++)
                if (en[k])
                    v_reg[k] <= v_reg[k-1];
        end
    end

    // stage 0: edges
    logic signed [EW-1:0] e1x_reg, e1y_reg, e1z_reg, e2x_reg, e2y_reg, e2z_reg;
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            e1x_reg <= EW'(bx) - EW'(ax);
            e1y_reg <= EW'(by) - EW'(ay);
            e1z_reg <= EW'(bz) - EW'(az);
            e2x_reg <= EW'(cx) - EW'(ax);
            e2y_reg <= EW'(cy) - EW'(ay);
            e2z_reg <= EW'(cz) - EW'(az);
        end
    end

    // stage 1: six products
    logic signed [PW-1:0] p_reg [6];
    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            p_reg[0] <= PW'(e1y_reg) * PW'(e2z_reg);
            p_reg[1] <= PW'(e1z_reg) * PW'(e2y_reg);
            p_reg[2] <= PW'(e1z_reg) * PW'(e2x_reg);
            p_reg[3] <= PW'(e1x_reg) * PW'(e2z_reg);
            p_reg[4] <= PW'(e1x_reg) * PW'(e2y_reg);
            p_reg[5] <= PW'(e1y_reg) * PW'(e2x_reg);
        end
    end

    // stage 2: cross product magnitude and sign
    logic signed [PW:0] n_w [3];
    logic [MW-1:0]      mag_reg [3];
    logic [2:0]         sgn2_reg;
    always_comb
    begin
        for (int i = 0; i < 3; i++)
            n_w[i] = (PW+1)'(p_reg[2*i]) - (PW+1)'(p_reg[2*i+1]);
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            for (int i = 0; i < 3; i++)
            begin
                mag_reg[i]  <= n_w[i][PW] ? MW'(-n_w[i]) : MW'(n_w[i]);
                sgn2_reg[i] <= n_w[i][PW];
            end
        end
    end

    // stage 3: partial products of the squares
    logic [2*HW-1:0]    hh_reg [3];
    logic [HW+LW-1:0]   hl_reg [3];
    logic [2*LW-1:0]    ll_reg [3];
    logic [2:0]         sgn3_reg;
    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            for (int i = 0; i < 3; i++)
            begin
                hh_reg[i] <= (2*HW)'(mag_reg[i][MW-1:LW]) * (2*HW)'(mag_reg[i][MW-1:LW]);
                hl_reg[i] <= (HW+LW)'(mag_reg[i][MW-1:LW]) * (HW+LW)'(mag_reg[i][LW-1:0]);
                ll_reg[i] <= (2*LW)'(mag_reg[i][LW-1:0]) * (2*LW)'(mag_reg[i][LW-1:0]);
            end
            sgn3_reg <= sgn2_reg;
        end
    end

    // stage 4: squares
    logic [SQW-1:0] sq_reg [3];
    logic [2:0]     sgn4_reg;
    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            for (int i = 0; i < 3; i++)
                sq_reg[i] <= (SQW'(hh_reg[i]) << (2 * LW)) + (SQW'(hl_reg[i]) << (LW + 1))
                           + SQW'(ll_reg[i]);
            sgn4_reg <= sgn3_reg;
        end
    end

    // stage 5: squared length and 4K^2 * n_i^2 by shift and add
    logic signed [IW-1:0] sqw [3];
    logic [L2W-1:0]       len_sum;
    logic [L2W-1:0]       len2_reg;
    logic signed [IW-1:0] rhs_reg [3];
    logic [2:0]           sgn5_reg;
    logic                 deg5_reg;
    always_comb
    begin
        for (int i = 0; i < 3; i++)
            sqw[i] = $signed(IW'(sq_reg[i]));
        len_sum = L2W'(sq_reg[0]) + L2W'(sq_reg[1]) + L2W'(sq_reg[2]);
    end

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            len2_reg <= len_sum;
            for (int i = 0; i < 3; i++)
                rhs_reg[i] <= (sqw[i] <<< (2 * NF + 2)) - (sqw[i] <<< (NF + 3))
                            + (sqw[i] <<< 2);
            sgn5_reg <= sgn4_reg;
            deg5_reg <= (len_sum == '0);
        end
    end

    // root lanes
    logic [NF-1:0] lmag [3];
    logic [2:0]    lneg;
    for (genvar i = 0; i < 3; i++) begin : g_lane
        tfn_lane u_lane (
            .clk     (clk),
            .en      (en[NFRONT +: NF]),
            .len2    (len2_reg),
            .rhs     (rhs_reg[i]),
            .neg     (sgn5_reg[i]),
            .mag     (lmag[i]),
            .neg_out (lneg[i])
        );
    end

    logic [NF-1:0] deg_reg;
    always_ff @(posedge clk)
    begin
        if (en[NFRONT])
            deg_reg[0] <= deg5_reg;
        for (int k = 1; k < NF; k++)
            if (en[NFRONT+k])
                deg_reg[k] <= deg_reg[k-1];
    end

    // output register
    logic signed [NF:0]   sm [3];
    logic signed [FW-1:0] nx_reg, ny_reg, nz_reg;
    logic                 deg_out_reg;
    always_comb
    begin
        for (int i = 0; i < 3; i++)
            sm[i] = lneg[i] ? -$signed({1'b0, lmag[i]}) : $signed({1'b0, lmag[i]});
    end

    always_ff @(posedge clk)
    begin
        if (en[NST-1])
        begin
            nx_reg      <= deg_reg[NF-1] ? '0 : FW'(sm[0]);
            ny_reg      <= deg_reg[NF-1] ? '0 : FW'(sm[1]);
            nz_reg      <= deg_reg[NF-1] ? '0 : FW'(sm[2]);
            deg_out_reg <= deg_reg[NF-1];
        end
    end

    assign normal_x   = nx_reg;
    assign normal_y   = ny_reg;
    assign normal_z   = nz_reg;
    assign degenerate = deg_out_reg;

    `TFN_ASSERT(a_deg_zero, clk, rst_n, out_valid && degenerate |-> normal_x == 0 && normal_y == 0 && normal_z == 0, "degenerate result with nonzero normal")
    `TFN_ASSERT(a_nondeg_nonzero, clk, rst_n, out_valid && !degenerate |-> normal_x != 0 || normal_y != 0 || normal_z != 0, "nondegenerate result with zero normal")
    `TFN_ASSERT(a_stall_full, clk, rst_n, in_stall |-> out_valid && out_stall && (&v_reg), "input stalled while pipeline has room")
endmodule
`default_nettype wire
